// ===== rtl/jsu_pkg.sv =====
// Shared types and codes for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_UNTERM    = 3'd0,
    ERR_ESCAPE    = 3'd1,
    ERR_UNICODE   = 3'd2,
    ERR_SURROGATE = 3'd3,
    ERR_CONTROL   = 3'd4
  } err_t;

  typedef enum logic [6:0] {
    MODE_PLAIN   = 7'b0000001,
    MODE_ESC     = 7'b0000010,
    MODE_HEX1    = 7'b0000100,
    MODE_WANT_BS = 7'b0001000,
    MODE_WANT_U  = 7'b0010000,
    MODE_HEX2    = 7'b0100000,
    MODE_DONE    = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [5:0] HIGH_SURR_TOP = 6'b110110;
  localparam logic [5:0] LOW_SURR_TOP  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // Results caused by one input transfer, at most four.
  typedef struct packed {
    logic             has;
    logic [1:0]       top_idx;
    logic [3:0][7:0]  bytes;
    kind_t            kind;
    err_t             code;
  } group_t;

endpackage

// ===== rtl/jsu_text_if.sv =====
// Input channel carrying string body bytes and the end marker.
interface jsu_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ===== rtl/jsu_result_if.sv =====
// Output channel carrying decoded bytes, close and error results.
interface jsu_result_if;
  logic          valid;
  logic          ready;
  logic [7:0]    out_byte;
  jsu_pkg::kind_t kind;
  jsu_pkg::err_t  error_code;
  logic          last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

// ===== rtl/jsu_decode.sv =====
// Escape decoder state and the results one input byte causes.
module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       in_byte,
  input  logic             end_of_text,
  output jsu_pkg::group_t  grp
);

  jsu_pkg::mode_t mode, mode_next;
  logic [1:0]     digit_count, digit_count_next;
  logic [15:0]    high_unit, high_unit_next;
  logic [15:0]    low_unit, low_unit_next;

  logic [3:0]  dval;
  logic        dok;
  logic [15:0] hu_sh;
  logic [15:0] lu_sh;
  logic [20:0] cp;

  always_comb begin
    dok  = 1'b1;
    dval = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      dval = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      dval = in_byte[3:0] + 4'd9;
    end else begin
      dok = 1'b0;
    end
  end

  assign hu_sh = {high_unit[11:0], dval};
  assign lu_sh = {low_unit[11:0], dval};
  assign cp    = jsu_pkg::SUPP_BASE + {1'b0, high_unit[9:0], lu_sh[9:0]};

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    high_unit_next   = high_unit;
    low_unit_next    = low_unit;
    grp              = '0;
    grp.kind         = jsu_pkg::KIND_DATA;
    grp.code         = jsu_pkg::ERR_UNTERM;
    if (end_of_text) begin
      unique case (mode)
        jsu_pkg::MODE_PLAIN, jsu_pkg::MODE_ESC: begin
          grp.has = 1'b1;
          grp.kind = jsu_pkg::KIND_ERROR;
          grp.code = jsu_pkg::ERR_UNTERM;
          mode_next = jsu_pkg::MODE_DONE;
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          grp.has = 1'b1;
          grp.kind = jsu_pkg::KIND_ERROR;
          grp.code = jsu_pkg::ERR_UNICODE;
          mode_next = jsu_pkg::MODE_DONE;
        end
        jsu_pkg::MODE_WANT_BS, jsu_pkg::MODE_WANT_U: begin
          grp.has = 1'b1;
          grp.kind = jsu_pkg::KIND_ERROR;
          grp.code = jsu_pkg::ERR_SURROGATE;
          mode_next = jsu_pkg::MODE_DONE;
        end
        default: begin
          mode_next        = jsu_pkg::MODE_PLAIN;
          digit_count_next = 2'd0;
          high_unit_next   = 16'd0;
          low_unit_next    = 16'd0;
        end
      endcase
    end else begin
      unique case (mode)
        jsu_pkg::MODE_PLAIN: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            grp.has = 1'b1;
            grp.kind = jsu_pkg::KIND_CLOSE;
            mode_next = jsu_pkg::MODE_DONE;
          end else if (in_byte == jsu_pkg::CH_BSL) begin
            mode_next = jsu_pkg::MODE_ESC;
          end else if (in_byte < 8'h20) begin
            grp.has = 1'b1;
            grp.kind = jsu_pkg::KIND_ERROR;
            grp.code = jsu_pkg::ERR_CONTROL;
            mode_next = jsu_pkg::MODE_DONE;
          end else begin
            grp.has = 1'b1;
            grp.bytes[0] = in_byte;
          end
        end
        jsu_pkg::MODE_ESC: begin
          mode_next = jsu_pkg::MODE_PLAIN;
          grp.has = 1'b1;
          case (in_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: grp.bytes[0] = in_byte;
            jsu_pkg::CH_B: grp.bytes[0] = 8'h08;
            jsu_pkg::CH_F: grp.bytes[0] = 8'h0C;
            jsu_pkg::CH_N: grp.bytes[0] = 8'h0A;
            jsu_pkg::CH_R: grp.bytes[0] = 8'h0D;
            jsu_pkg::CH_T: grp.bytes[0] = 8'h09;
            jsu_pkg::CH_U: begin
              grp.has          = 1'b0;
              mode_next        = jsu_pkg::MODE_HEX1;
              digit_count_next = 2'd0;
              high_unit_next   = 16'd0;
            end
            default: begin
              grp.kind  = jsu_pkg::KIND_ERROR;
              grp.code  = jsu_pkg::ERR_ESCAPE;
              mode_next = jsu_pkg::MODE_DONE;
            end
          endcase
        end
        jsu_pkg::MODE_HEX1: begin
          if (!dok) begin
            grp.has = 1'b1;
            grp.kind = jsu_pkg::KIND_ERROR;
            grp.code = jsu_pkg::ERR_UNICODE;
            mode_next = jsu_pkg::MODE_DONE;
          end else begin
            high_unit_next = hu_sh;
            if (digit_count != 2'd3) begin
              digit_count_next = digit_count + 2'd1;
            end else begin
              digit_count_next = 2'd0;
              if (hu_sh[15:10] == jsu_pkg::HIGH_SURR_TOP) begin
                mode_next = jsu_pkg::MODE_WANT_BS;
              end else begin
                mode_next = jsu_pkg::MODE_PLAIN;
                grp.has = 1'b1;
                if (hu_sh[15:7] == 9'd0) begin
                  grp.bytes[0] = hu_sh[7:0];
                end else if (hu_sh[15:11] == 5'd0) begin
                  grp.top_idx  = 2'd1;
                  grp.bytes[0] = {3'b110, hu_sh[10:6]};
                  grp.bytes[1] = {2'b10, hu_sh[5:0]};
                end else begin
                  grp.top_idx  = 2'd2;
                  grp.bytes[0] = {4'b1110, hu_sh[15:12]};
                  grp.bytes[1] = {2'b10, hu_sh[11:6]};
                  grp.bytes[2] = {2'b10, hu_sh[5:0]};
                end
              end
            end
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          if (in_byte != jsu_pkg::CH_BSL) begin
            grp.has = 1'b1;
            grp.kind = jsu_pkg::KIND_ERROR;
            grp.code = jsu_pkg::ERR_SURROGATE;
            mode_next = jsu_pkg::MODE_DONE;
          end else begin
            mode_next = jsu_pkg::MODE_WANT_U;
          end
        end
        jsu_pkg::MODE_WANT_U: begin
          if (in_byte != jsu_pkg::CH_U) begin
            grp.has = 1'b1;
            grp.kind = jsu_pkg::KIND_ERROR;
            grp.code = jsu_pkg::ERR_SURROGATE;
            mode_next = jsu_pkg::MODE_DONE;
          end else begin
            mode_next        = jsu_pkg::MODE_HEX2;
            digit_count_next = 2'd0;
            low_unit_next    = 16'd0;
          end
        end
        jsu_pkg::MODE_HEX2: begin
          if (!dok) begin
            grp.has = 1'b1;
            grp.kind = jsu_pkg::KIND_ERROR;
            grp.code = jsu_pkg::ERR_UNICODE;
            mode_next = jsu_pkg::MODE_DONE;
          end else begin
            low_unit_next = lu_sh;
            if (digit_count != 2'd3) begin
              digit_count_next = digit_count + 2'd1;
            end else begin
              digit_count_next = 2'd0;
              grp.has = 1'b1;
              if (lu_sh[15:10] != jsu_pkg::LOW_SURR_TOP) begin
                grp.kind = jsu_pkg::KIND_ERROR;
                grp.code = jsu_pkg::ERR_SURROGATE;
                mode_next = jsu_pkg::MODE_DONE;
              end else begin
                mode_next    = jsu_pkg::MODE_PLAIN;
                grp.top_idx  = 2'd3;
                grp.bytes[0] = {5'b11110, cp[20:18]};
                grp.bytes[1] = {2'b10, cp[17:12]};
                grp.bytes[2] = {2'b10, cp[11:6]};
                grp.bytes[3] = {2'b10, cp[5:0]};
              end
            end
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jsu_pkg::MODE_PLAIN;
      digit_count <= 2'd0;
      high_unit   <= 16'd0;
      low_unit    <= 16'd0;
    end else if (take) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      high_unit   <= high_unit_next;
      low_unit    <= low_unit_next;
    end
  end

endmodule

// ===== rtl/jsu_emit.sv =====
// Result register that presents the bytes of one group one per transfer.
module jsu_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  jsu_pkg::group_t grp_in,
  output logic            free,
  jsu_result_if.source    dst
);

  jsu_pkg::group_t grp;
  logic            busy;
  logic [1:0]      idx;
  logic            at_last;

  assign at_last        = idx == grp.top_idx;
  assign free           = !busy || (dst.ready && at_last);
  assign dst.valid      = busy;
  assign dst.out_byte   = grp.bytes[idx];
  assign dst.kind       = grp.kind;
  assign dst.error_code = grp.code;
  assign dst.last       = at_last;

  always_ff @(posedge clk) begin
    if (take && grp_in.has) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take && grp_in.has) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && dst.ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string body unescaper with UTF-8 output.
// One byte of the string body is taken per transfer on text, starting after the
// opening quote; each byte is decoded in the cycle it is taken and its results
// are registered for the result channel the next cycle. A byte that gives one
// result, or none, is taken every cycle while the result side keeps up. A
// \uXXXX escape that ends in 2, 3 or 4 UTF-8 bytes holds the result register
// as its bytes go out, and text is stalled until its last byte is transferred;
// the result register is the only thing that limits the rate. Close and error
// results come as a single transfer with last set, after which further bytes
// are taken without result until an end_of_text transfer rearms the block.
module json_string_unescape_utf8 (
  input logic          clk,
  input logic          rst,
  jsu_text_if.sink     text,
  jsu_result_if.source result
);

  jsu_pkg::group_t grp;
  logic            free;
  logic            take;

  assign text.ready = free;
  assign take       = text.valid && free;

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (text.in_byte),
    .end_of_text (text.end_of_text),
    .grp         (grp)
  );

  jsu_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .grp_in (grp),
    .free   (free),
    .dst    (result)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !text.ready)
    else $error("Input taken while a result is stalled.");

  a_ctrl_single: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != jsu_pkg::KIND_DATA) |-> result.last)
    else $error("Close or error result is not the last of its group.");

  a_group_cont: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !result.last) |=> result.valid)
    else $error("Group of UTF-8 bytes cut short.");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != jsu_pkg::KIND_ERROR) |->
      (result.error_code == jsu_pkg::ERR_UNTERM))
    else $error("Error code set on a non-error result.");

endmodule
